[rtl/sha512_pkg.sv]
package sha512_pkg;

    typedef logic [63:0] t_word;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } t_blk_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD
    } t_core_state;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    localparam t_word PAD_WORD = 64'h8000_0000_0000_0000;

    localparam t_word START_HASH [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam t_word ROUND_K [80] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
        64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
        64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
        64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
        64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
        64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
        64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
        64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
        64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
        64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
        64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
        64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
        64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
        64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
        64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
        64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
        64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
        64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
        64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
        64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
        64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

[rtl/sha512_front.sv]
// Front end: counts bytes, masks and pads the tail, emits full 16-word blocks
// one word a cycle into the block queue while the queue accepts.
module sha512_front
    import sha512_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  logic [63:0] i_word,
    input  logic [3:0]  i_nbytes,
    input  logic        i_last,
    output logic        o_q_valid,
    input  logic        i_q_ready,
    output t_blk_word   o_q_data
);

    logic [63:0] r_bytes, n_bytes;
    logic [3:0]  r_fill, n_fill;
    logic        r_pad, n_pad;      // emitting padding words
    logic        r_len_blk, n_len_blk;
    logic        r_pend_pad, n_pend_pad; // 0x80 word still to emit
    logic [3:0]  v_sat;
    logic [63:0] v_keep, v_word;
    logic [6:0]  v_sh;

    always_comb begin
        v_sat  = (i_nbytes > 4'd8) ? 4'd8 : i_nbytes;
        v_sh   = 7'd64 - {v_sat, 3'b000};
        v_keep = ~((64'd1 << v_sh) - 64'd1);
        v_word = (i_word & v_keep) | (64'h80 << (v_sh - 7'd8));
    end

    // a pad word landing in slot 14 leaves no room for the length: one more block
    always_comb begin
        n_bytes = r_bytes; n_fill = r_fill; n_pad = r_pad;
        n_len_blk = r_len_blk; n_pend_pad = r_pend_pad;
        o_ready   = !r_pad && i_q_ready;
        o_q_valid = 1'b0;
        o_q_data  = '{word: i_word, last: 1'b0};
        if (r_pad) begin
            o_q_valid = 1'b1;
            if (r_pend_pad)
                o_q_data.word = PAD_WORD;
            else if (r_fill == 4'd15 && !r_len_blk)
                o_q_data.word = {r_bytes[60:0], 3'b000};
            else
                o_q_data.word = '0;
            o_q_data.last = (r_fill == 4'd15) && !r_len_blk;
            if (i_q_ready) begin
                n_fill = r_fill + 4'd1;
                if (r_pend_pad) begin
                    n_pend_pad = 1'b0;
                    n_len_blk  = (r_fill == 4'd14);
                end else if (r_fill == 4'd15) begin
                    if (r_len_blk) n_len_blk = 1'b0;
                    else begin
                        n_pad = 1'b0; n_bytes = '0;
                    end
                end
            end
        end else if (i_valid) begin
            o_q_valid = 1'b1;
            if (i_last && v_sat != 4'd8 && v_sat != 4'd0)
                o_q_data.word = v_word;
            else if (i_last && v_sat == 4'd0)
                o_q_data.word = PAD_WORD;
            if (i_q_ready) begin
                n_fill = r_fill + 4'd1;
                if (i_last) begin
                    n_bytes    = r_bytes + {60'd0, v_sat};
                    n_pad      = 1'b1;
                    n_pend_pad = (v_sat == 4'd8);
                    n_len_blk  = (r_fill == 4'd14);
                end else begin
                    n_bytes = r_bytes + 64'd8;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0; r_fill <= '0; r_pad <= 1'b0;
            r_len_blk <= 1'b0; r_pend_pad <= 1'b0;
        end else begin
            r_bytes <= n_bytes; r_fill <= n_fill; r_pad <= n_pad;
            r_len_blk <= n_len_blk; r_pend_pad <= n_pend_pad;
        end
    end

endmodule

[rtl/sha512_queue.sv]
// Small FIFO between front end and round engine.
module sha512_queue
    import sha512_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_blk_word i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_blk_word o_data
);

    t_blk_word r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic v_push, v_pop;

    assign o_ready = (r_cnt != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign v_push  = i_valid && o_ready;
    assign v_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (v_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (v_push) r_wp <= r_wp + 1'b1;
            if (v_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(v_push) - (QUEUE_AW+1)'(v_pop);
        end
    end

endmodule

[rtl/sha512_rounds.sv]
// Round engine: loads 16 words, runs 80 rounds one per cycle, folds into hash,
// then streams the digest after the block flagged last.
module sha512_rounds
    import sha512_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_blk_word i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output logic [63:0] o_word,
    output logic        o_last
);

    t_core_state r_state, n_state;
    t_word r_h [8];
    t_word r_v [8];
    t_word r_w [16];
    logic [3:0] r_fill;
    logic [6:0] r_rnd;
    logic       r_final;
    logic       r_out;
    logic [2:0] r_oidx;

    t_word v_wt, v_s0, v_s1, v_t1, v_t2, v_new;
    logic  v_load;

    always_comb begin
        v_s0  = rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        v_s1  = rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        v_new = r_w[0] + v_s0 + r_w[9] + v_s1;
        v_wt  = r_w[0];
        v_t1  = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_rnd] + v_wt;
        v_t2  = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (v_load && r_fill == 4'd15) n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 7'd79) n_state = ST_FOLD;
            ST_FOLD:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == ST_IDLE) && !r_out;
        o_valid = r_out;
        o_word  = r_h[r_oidx];
        o_last  = (r_oidx == 3'd7);
    end
    assign v_load = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (v_load) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_data.word;
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= v_new;
        end
        if (r_state == ST_IDLE) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_state == ST_ROUND) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + v_t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= v_t1 + v_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_fill <= '0; r_rnd <= '0; r_final <= 1'b0;
            r_out <= 1'b0; r_oidx <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= START_HASH[i];
        end else begin
            r_state <= n_state;
            if (v_load) begin
                r_fill <= r_fill + 4'd1;
                if (r_fill == 4'd15) r_final <= i_data.last;
            end
            if (r_state == ST_ROUND) r_rnd <= r_rnd + 7'd1;
            else r_rnd <= '0;
            if (r_state == ST_FOLD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_out <= r_final;
            end
            if (r_out && i_ready) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_out <= 1'b0;
                    for (int i = 0; i < 8; i++) r_h[i] <= START_HASH[i];
                end
            end
        end
    end

endmodule

[rtl/sha512_stream_hasher_core.sv]
// SHA-512 over a stream of big-endian 64-bit words. One word a beat; the last
// word (tlast) carries 0..8 left-aligned valid bytes in tuser, above 8 counts
// as 8. The front end pads in hardware and feeds 16-word blocks through a
// four-entry queue to the round engine, which runs one round per cycle: a block
// is loaded word by word, run through 80 rounds and folded into the hash before
// the next block is taken. After the last block the eight digest words leave on
// the master side, word 0 first, tlast on word 7; the state then returns to the
// initial hash for the next message. Words are taken while the digest waits
// only up to the queue depth.
module sha512_stream_hasher_core
    import sha512_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // message_word
    input  logic [3:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic        m_axis_tlast    // digest_last
);

    t_blk_word w_fq_data, w_qr_data;
    logic w_fq_valid, w_fq_ready, w_qr_valid, w_qr_ready;

    sha512_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_word(s_axis_tdata), .i_nbytes(s_axis_tuser), .i_last(s_axis_tlast),
        .o_q_valid(w_fq_valid), .i_q_ready(w_fq_ready), .o_q_data(w_fq_data)
    );

    sha512_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fq_valid), .o_ready(w_fq_ready), .i_data(w_fq_data),
        .o_valid(w_qr_valid), .i_ready(w_qr_ready), .o_data(w_qr_data)
    );

    sha512_rounds u_rounds (
        .i_clk, .i_rst_n,
        .i_valid(w_qr_valid), .o_ready(w_qr_ready), .i_data(w_qr_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(m_axis_tdata), .o_last(m_axis_tlast)
    );

endmodule

[rtl/sha512_checker.sv]
module sha512_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest beat dropped under stall");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("digest valid right after reset");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("digest continues past last word");

endmodule

bind sha512_stream_hasher_core sha512_checker u_checker (.*);
